/* design/point_in_polygon_test_macros.svh */
// Assertion macros shared by the point-in-polygon checker.
// Each macro expands to one labelled concurrent assertion clocked on the given clock.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pip check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pip check failed");

`endif

/* design/pip_pkg.sv */
// Shared types and constants of the point-in-polygon test block.
// No dependencies; every other design file but the assertion macro header refers to it by scoped names.
`timescale 1ns / 1ps

package pip_pkg;

    localparam int COORD_W = 24;          // coordinate width, 8 fraction bits
    localparam int DIFF_W  = COORD_W + 1; // difference of two coordinates
    localparam int PROD_W  = 2 * DIFF_W;  // product of two differences
    localparam int CNT_W   = 5;           // width of the vertex count register
    localparam int IDX_W   = 4;           // width of the vertex index field
    localparam int MIN_VERTICES = 3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vertex;

    typedef struct packed {
        logic    vld;
        t_vertex prev;
        t_vertex cur;
    } t_edge_req;

    typedef struct packed {
        logic busy;
        logic vld;
        logic hit;
    } t_edge_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

endpackage

/* design/pip_cell.sv */
// One storage cell of the rotating vertex chain.
// Depends on pip_pkg for the vertex type.
`timescale 1ns / 1ps

module pip_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  pip_pkg::t_vertex i_load_vtx,
    input  logic             i_shift,
    input  pip_pkg::t_vertex i_next_vtx,
    output pip_pkg::t_vertex o_vtx
);

    pip_pkg::t_vertex r_vtx;
    pip_pkg::t_vertex n_vtx;

    // A load only happens while the chain is parked, so the two never collide.
    always_comb begin
        n_vtx = r_vtx;
        if (i_load) begin
            n_vtx = i_load_vtx;
        end else if (i_shift) begin
            n_vtx = i_next_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtx <= n_vtx;
    end

    assign o_vtx = r_vtx;

endmodule

/* design/pip_edge_unit.sv */
// Pipelined edge crossing unit: registered differences, registered cross products, combinational signed compare.
// Depends on pip_pkg for the vertex and request/response types.
`timescale 1ns / 1ps

module pip_edge_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pip_pkg::t_edge_req i_req,
    input  pip_pkg::t_vertex   i_pt,
    output pip_pkg::t_edge_rsp o_rsp
);

    localparam int DW = pip_pkg::DIFF_W;
    localparam int PW = pip_pkg::PROD_W;

    logic                 r_a_vld;
    logic                 r_a_cross;
    logic signed [DW-1:0] r_a_dxt;
    logic signed [DW-1:0] r_a_dy;
    logic signed [DW-1:0] r_a_dxe;
    logic signed [DW-1:0] r_a_dty;

    logic                 r_b_vld;
    logic                 r_b_cross;
    logic                 r_b_neg;
    logic signed [PW-1:0] r_b_lhs;
    logic signed [PW-1:0] r_b_rhs;

    logic                 n_cross;
    logic signed [DW-1:0] n_dxt;
    logic signed [DW-1:0] n_dy;
    logic signed [DW-1:0] n_dxe;
    logic signed [DW-1:0] n_dty;

    // The current vertex is the edge's base point; the previous one is its far end.
    always_comb begin
        n_cross = (i_req.cur.y > i_pt.y) != (i_req.prev.y > i_pt.y);
        n_dxt   = DW'(i_pt.x) - DW'(i_req.cur.x);
        n_dy    = DW'(i_req.prev.y) - DW'(i_req.cur.y);
        n_dxe   = DW'(i_req.prev.x) - DW'(i_req.cur.x);
        n_dty   = DW'(i_pt.y) - DW'(i_req.cur.y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_req.vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_cross <= n_cross;
        r_a_dxt   <= n_dxt;
        r_a_dy    <= n_dy;
        r_a_dxe   <= n_dxe;
        r_a_dty   <= n_dty;
        r_b_cross <= r_a_cross;
        r_b_neg   <= r_a_dy[DW-1];
        r_b_lhs   <= PW'(r_a_dxt) * PW'(r_a_dy);
        r_b_rhs   <= PW'(r_a_dxe) * PW'(r_a_dty);
    end

    // Multiplying through by the y span flips the inequality when the span is negative.
    always_comb begin
        o_rsp.busy = r_a_vld | r_b_vld;
        o_rsp.vld  = r_b_vld;
        o_rsp.hit  = r_b_cross & (r_b_neg ? (r_b_lhs > r_b_rhs) : (r_b_lhs < r_b_rhs));
    end

endmodule

/* design/point_in_polygon_test.sv */
// Point-in-polygon test by the even-odd ray-crossing rule.
//
// Input channel (i_in_valid / o_in_ready): a load transfer (kind 0) writes one
// vertex into slot vertex_index; slots at or beyond MAX_VERTICES are dropped.
// A test transfer (kind 1) gives a point and yields one inside flag on the
// result channel (o_res_valid / i_res_ready). Loads give no result.
// Configuration channel (i_cfg_valid / o_cfg_ready) sets vertex_count; a
// count below three answers outside, one above MAX_VERTICES is clipped.
// A test closes the input channel while the vertex chain rotates once past the
// edge unit and the edge pipeline drains. The result is offered as the input
// channel reopens, so a new test is taken only once the last one is through,
// each test passing its edges in turn through the single edge unit.
// The result sits in an output register; a stalled receiver delays only the
// completion of the next test, and loads are still accepted meanwhile.
// Reset clears the count and the control state; the vertex table is left
// undefined until written.
`timescale 1ns / 1ps

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [pip_pkg::IDX_W-1:0]           i_vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_coord_y,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_inside_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pip_pkg::CNT_W-1:0]           i_cfg_vertex_count
);

    localparam int NW = $clog2(MAX_VERTICES + 1);

    pip_pkg::t_state            r_state;
    pip_pkg::t_state            n_state;
    logic [pip_pkg::CNT_W-1:0]  r_vertex_count;
    logic [NW-1:0]              r_k;
    logic                       r_parity;
    logic                       r_out_vld;
    logic                       r_out_res;
    pip_pkg::t_vertex           r_pt;
    pip_pkg::t_vertex           r_first;
    pip_pkg::t_vertex           r_prev;

    pip_pkg::t_vertex           w_vtx [MAX_VERTICES];
    pip_pkg::t_vertex           w_in_vtx;
    pip_pkg::t_edge_req         w_req;
    pip_pkg::t_edge_rsp         w_rsp;
    logic [NW-1:0]              w_n_eff;
    logic                       w_in_xfer;
    logic                       w_load;
    logic                       w_start;
    logic                       w_run;
    logic                       w_finish;

    assign w_in_vtx.x = i_coord_x;
    assign w_in_vtx.y = i_coord_y;
    assign w_in_xfer  = i_in_valid & o_in_ready;
    assign w_load     = w_in_xfer & (i_kind == pip_pkg::KIND_LOAD);
    assign w_start    = w_in_xfer & (i_kind == pip_pkg::KIND_TEST);

    assign w_n_eff = (32'(r_vertex_count) > MAX_VERTICES)
                     ? NW'(MAX_VERTICES) : NW'(r_vertex_count);

    // Cell g takes its neighbour g+1 on a shift, so cell 0 shows each vertex in turn
    // and a full rotation brings every vertex back to its own slot.
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        pip_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_load && ({28'd0, i_vertex_index} == 32'(g))),
            .i_load_vtx (w_in_vtx),
            .i_shift    (w_run && (r_k != NW'(MAX_VERTICES))),
            .i_next_vtx (w_vtx[(g + 1) % MAX_VERTICES]),
            .o_vtx      (w_vtx[g])
        );
    end

    // Step k pairs the previous vertex with vertex k; the closing edge uses the first.
    always_comb begin
        w_req.vld  = w_run && (r_k != '0) && (r_k <= w_n_eff);
        w_req.prev = r_prev;
        w_req.cur  = (r_k == w_n_eff) ? r_first : w_vtx[0];
    end

    pip_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_pt    (r_pt),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pip_pkg::ST_IDLE: begin
                if (w_start) begin
                    n_state = pip_pkg::ST_RUN;
                end
            end
            pip_pkg::ST_RUN: begin
                if (r_k == NW'(MAX_VERTICES)) begin
                    n_state = pip_pkg::ST_FLUSH;
                end
            end
            pip_pkg::ST_FLUSH: begin
                if (w_finish) begin
                    n_state = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pip_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_run      = 1'b0;
        w_finish   = 1'b0;
        unique case (r_state)
            pip_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            pip_pkg::ST_RUN: begin
                w_run = 1'b1;
            end
            pip_pkg::ST_FLUSH: begin
                w_finish = !w_rsp.busy && (!r_out_vld || i_res_ready);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= pip_pkg::ST_IDLE;
            r_vertex_count <= '0;
            r_k            <= '0;
            r_parity       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_vertex_count <= i_cfg_vertex_count;
            end
            if (w_start) begin
                r_k <= '0;
            end else if (w_run) begin
                r_k <= r_k + NW'(1);
            end
            if (w_start) begin
                r_parity <= 1'b0;
            end else if (w_rsp.vld && w_rsp.hit) begin
                r_parity <= ~r_parity;
            end
            if (w_finish) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_pt    <= w_in_vtx;
            r_first <= w_vtx[0];
        end
        if (w_run) begin
            r_prev <= w_vtx[0];
        end
        if (w_finish) begin
            r_out_res <= r_parity & (w_n_eff >= NW'(pip_pkg::MIN_VERTICES));
        end
    end

    assign o_res_valid  = r_out_vld;
    assign o_inside_res = r_out_res;
    assign o_cfg_ready  = 1'b1;

endmodule

/* design/pip_checker.sv */
// Port-level checker for the point-in-polygon test block, bound to the top level.
// Depends on pip_pkg and the assertion macros in point_in_polygon_test_macros.svh.
`timescale 1ns / 1ps
`include "point_in_polygon_test_macros.svh"

module pip_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                i_kind,
    input logic [pip_pkg::IDX_W-1:0]           i_vertex_index,
    input logic signed [pip_pkg::COORD_W-1:0]  i_coord_x,
    input logic signed [pip_pkg::COORD_W-1:0]  i_coord_y,
    input logic                                o_res_valid,
    input logic                                i_res_ready,
    input logic                                o_inside_res,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [pip_pkg::CNT_W-1:0]           i_cfg_vertex_count
);

    // A stalled result must neither vanish nor change.
    `PIP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid && $stable(o_inside_res))

    // A test transfer occupies the block, so the input side closes at once.
    `PIP_ASSERT_NEXT(a_test_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind == pip_pkg::KIND_TEST, !o_in_ready)

    // A load transfer never produces a result.
    `PIP_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind == pip_pkg::KIND_LOAD && !o_res_valid, !o_res_valid)

    // A fresh result only follows a cycle in which a test was still being worked on.
    `PIP_ASSERT_NOW(a_res_after_work, i_clk, i_rst_n, $rose(o_res_valid), !$past(o_in_ready))

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
